// File: design/ckis_pkg.sv
// Shared types and constants for the chunked index key search block.
package ckis_pkg;

    // Field widths fixed by the item layout
    localparam int KEY_W  = 32;
    localparam int OFFS_W = 31;
    localparam int SLOT_W = 10;
    localparam int CNT_W  = 11;
    localparam int KIND_W = 2;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_MATCH = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DONE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TRUNC = 2'd2;

    // Input command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic write;        // store one entry
        logic start;        // latch query key and entry count
        logic chunk_begin;  // open next chunk for the lower-bound search
        logic tail_begin;   // open the unsorted tail scan
        logic use_mid;      // memory address is the probe midpoint
        logic probe_update; // narrow the search window
        logic scan_next;    // step the scan index
        logic emit_match;   // load a match beat into the output register
        logic set_trunc;    // remember that the match limit was hit
        logic emit_close;   // load the closing beat
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic chunk_avail;  // a whole chunk remains before the tail
        logic search_open;  // lower-bound window not empty
        logic scan_open;    // scan index below its end
        logic key_lt;       // read key below query key (signed)
        logic key_eq;       // read key equals query key
        logic at_limit;     // match count reached the limit
        logic out_free;     // output register can take a beat
    } t_dp_sts;

endpackage

// File: design/ckis_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ckis_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/ckis_dp.sv
// Datapath: entry table, search window counters, match count and output register.
module ckis_dp
    import ckis_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int CHUNK       = 64,
    parameter int MAX_MATCHES = 63
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_sts           o_sts,
    input  logic              i_cfg_we,
    input  logic [CNT_W-1:0]  i_cfg_data,
    input  logic [SLOT_W-1:0] i_wr_slot,
    input  logic [KEY_W-1:0]  i_wr_key,
    input  logic [OFFS_W-1:0] i_wr_offset,
    input  logic [KEY_W-1:0]  i_search_key,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [KIND_W-1:0] o_out_kind,
    output logic [OFFS_W-1:0] o_out_offset,
    output logic              o_out_last
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int PW = AW + 1;
    localparam int MW = $clog2(MAX_MATCHES + 1);
    localparam int EW = KEY_W + OFFS_W;

    // Control and payload registers
    logic [CNT_W-1:0]  r_entry_count;
    logic [KEY_W-1:0]  r_want, n_want;
    logic [PW-1:0]     r_cnt, n_cnt;
    logic [PW-1:0]     r_base, n_base;
    logic [PW-1:0]     r_lo, n_lo;
    logic [PW-1:0]     r_hi, n_hi;
    logic [PW-1:0]     r_end, n_end;
    logic [MW-1:0]     r_nmatch, n_nmatch;
    logic              r_trunc, n_trunc;
    logic              r_out_valid, n_out_valid;
    logic [KIND_W-1:0] r_out_kind, n_out_kind;
    logic [OFFS_W-1:0] r_out_offset, n_out_offset;
    logic              r_out_last, n_out_last;

    logic [31:0]       w_chunk_end;
    logic [PW-1:0]     w_mid;
    logic [EW-1:0]     w_rdata;
    logic [KEY_W-1:0]  w_rd_key;
    logic [OFFS_W-1:0] w_rd_offset;
    logic              w_we;
    logic [AW-1:0]     w_raddr;
    logic              w_out_free;

    // Entry table, key in the upper bits
    assign w_we = i_cmd.write && (32'(i_wr_slot) < 32'(TABLE_DEPTH));
    assign w_raddr = i_cmd.use_mid ? w_mid[AW-1:0] : r_lo[AW-1:0];

    ckis_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (AW'(i_wr_slot)),
        .i_wdata ({i_wr_key, i_wr_offset}),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_rd_key    = w_rdata[EW-1:OFFS_W];
    assign w_rd_offset = w_rdata[OFFS_W-1:0];

    // Window arithmetic
    assign w_chunk_end = 32'(r_base) + 32'(CHUNK);
    assign w_mid       = r_lo + ((r_hi - r_lo) >> 1);
    assign w_out_free  = !r_out_valid || i_out_ready;

    // Status
    always_comb begin
        o_sts.chunk_avail = w_chunk_end <= 32'(r_cnt);
        o_sts.search_open = r_lo < r_hi;
        o_sts.scan_open   = r_lo < r_end;
        o_sts.key_lt      = $signed(w_rd_key) < $signed(r_want);
        o_sts.key_eq      = w_rd_key == r_want;
        o_sts.at_limit    = r_nmatch >= MW'(MAX_MATCHES);
        o_sts.out_free    = w_out_free;
    end

    // Next-state logic
    always_comb begin
        n_want       = r_want;
        n_cnt        = r_cnt;
        n_base       = r_base;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_end        = r_end;
        n_nmatch     = r_nmatch;
        n_trunc      = r_trunc;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_kind   = r_out_kind;
        n_out_offset = r_out_offset;
        n_out_last   = r_out_last;

        if (i_cmd.start) begin
            n_want   = i_search_key;
            n_base   = '0;
            n_nmatch = '0;
            n_trunc  = 1'b0;
            // saturate the entry count at the table depth
            if (32'(r_entry_count) > 32'(TABLE_DEPTH)) begin
                n_cnt = PW'(TABLE_DEPTH);
            end else begin
                n_cnt = PW'(r_entry_count);
            end
        end
        if (i_cmd.chunk_begin) begin
            n_lo   = r_base;
            n_hi   = PW'(w_chunk_end);
            n_end  = PW'(w_chunk_end);
            n_base = PW'(w_chunk_end);
        end
        if (i_cmd.tail_begin) begin
            n_lo  = r_base;
            n_end = r_cnt;
        end
        if (i_cmd.probe_update) begin
            if (o_sts.key_lt) begin
                n_lo = w_mid + PW'(1);
            end else begin
                n_hi = w_mid;
            end
        end
        if (i_cmd.scan_next) begin
            n_lo = r_lo + PW'(1);
        end
        if (i_cmd.set_trunc) begin
            n_trunc = 1'b1;
        end
        // output register loads only when free
        if (i_cmd.emit_match) begin
            n_nmatch     = r_nmatch + MW'(1);
            n_out_valid  = 1'b1;
            n_out_kind   = KIND_MATCH;
            n_out_offset = w_rd_offset;
            n_out_last   = 1'b0;
        end
        if (i_cmd.emit_close) begin
            n_out_valid  = 1'b1;
            n_out_kind   = r_trunc ? KIND_TRUNC : KIND_DONE;
            n_out_offset = '0;
            n_out_last   = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
            r_out_valid   <= 1'b0;
            r_nmatch      <= '0;
            r_trunc       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_entry_count <= i_cfg_data;
            end
            r_out_valid <= n_out_valid;
            r_nmatch    <= n_nmatch;
            r_trunc     <= n_trunc;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_want       <= n_want;
        r_cnt        <= n_cnt;
        r_base       <= n_base;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_end        <= n_end;
        r_out_kind   <= n_out_kind;
        r_out_offset <= n_out_offset;
        r_out_last   <= n_out_last;
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_kind   = r_out_kind;
    assign o_out_offset = r_out_offset;
    assign o_out_last   = r_out_last;

endmodule

// File: design/ckis_ctrl.sv
// Controller: issues entry writes and sequences the chunk searches, run scans and tail scan of one query.
module ckis_ctrl
    import ckis_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_cmd,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE      = 7'b0000001,
        S_CHUNK     = 7'b0000010,
        S_PROBE_RD  = 7'b0000100,
        S_PROBE_CMP = 7'b0001000,
        S_SCAN_RD   = 7'b0010000,
        S_SCAN_CMP  = 7'b0100000,
        S_CLOSE     = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   r_tail, n_tail;

    assign o_in_ready = (r_state == S_IDLE);

    // Transitions and commands
    always_comb begin
        n_state = r_state;
        n_tail  = r_tail;
        o_cmd   = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_cmd == CMD_QUERY) begin
                        o_cmd.start = 1'b1;
                        n_tail      = 1'b0;
                        n_state     = S_CHUNK;
                    end else begin
                        o_cmd.write = 1'b1;
                    end
                end
            end
            S_CHUNK: begin
                if (i_sts.chunk_avail) begin
                    o_cmd.chunk_begin = 1'b1;
                    n_state           = S_PROBE_RD;
                end else begin
                    o_cmd.tail_begin = 1'b1;
                    n_tail           = 1'b1;
                    n_state          = S_SCAN_RD;
                end
            end
            S_PROBE_RD: begin
                o_cmd.use_mid = 1'b1;
                // empty window: lower bound found, walk the equal run
                n_state = i_sts.search_open ? S_PROBE_CMP : S_SCAN_RD;
            end
            S_PROBE_CMP: begin
                o_cmd.use_mid      = 1'b1;
                o_cmd.probe_update = 1'b1;
                n_state            = S_PROBE_RD;
            end
            S_SCAN_RD: begin
                if (i_sts.scan_open) begin
                    n_state = S_SCAN_CMP;
                end else begin
                    n_state = r_tail ? S_CLOSE : S_CHUNK;
                end
            end
            S_SCAN_CMP: begin
                if (i_sts.key_eq) begin
                    if (i_sts.at_limit) begin
                        o_cmd.set_trunc = 1'b1;
                        n_state         = S_CLOSE;
                    end else if (i_sts.out_free) begin
                        o_cmd.emit_match = 1'b1;
                        o_cmd.scan_next  = 1'b1;
                        n_state          = S_SCAN_RD;
                    end
                end else if (r_tail) begin
                    o_cmd.scan_next = 1'b1;
                    n_state         = S_SCAN_RD;
                end else begin
                    // end of the equal run in this chunk
                    n_state = S_CHUNK;
                end
            end
            S_CLOSE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_close = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tail  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_tail  <= n_tail;
        end
    end

endmodule

// File: design/chunked_index_key_search.sv
// Top level of the chunked index key search block.
//
// Input stream (s_axis): each beat is either an entry write (tuser = 0) that
// stores a key and row position into a table slot, or a query (tuser = 1).
// A write produces no output beat. A query searches each
// whole CHUNK of the first entry_count entries with a lower bound, emits the
// row positions of the run of equal keys, then scans the unsorted tail, and
// ends with one closing beat (tlast = 1, tuser = done or truncated).
// Output stream (m_axis): one beat per match, then the closing beat.
// Each lower-bound probe and each scan step is one registered read of the entry table.
// The input is taken only between queries; writes may pass while the last
// closing beat still sits in the output register.
// A stalled receiver holds the output register and pauses the scan.
// Reset (synchronous, active low) clears entry_count and the control state;
// table contents are undefined until written. Config: i_cfg_data sets entry_count,
// written by the user only while the block is idle; the block does not enforce this.
module chunked_index_key_search
    import ckis_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int CHUNK       = 64,
    parameter int MAX_MATCHES = 63
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CNT_W-1:0]   i_cfg_data,    // entry_count
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [111:0]       s_axis_tdata,  // entry_slot, entry_key, entry_offset, search_key
    input  logic [0:0]         s_axis_tuser,  // cmd
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [31:0]        m_axis_tdata,  // match_offset
    output logic [KIND_W-1:0]  m_axis_tuser,  // kind
    output logic               m_axis_tlast
);

    t_dp_cmd           w_cmd;
    t_dp_sts           w_sts;
    logic [OFFS_W-1:0] w_out_offset;

    assign o_cfg_ready = 1'b1;

    ckis_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_cmd   (s_axis_tuser[0]),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    ckis_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .CHUNK       (CHUNK),
        .MAX_MATCHES (MAX_MATCHES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_cfg_we     (i_cfg_valid && o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_wr_slot    (s_axis_tdata[9:0]),
        .i_wr_key     (s_axis_tdata[41:10]),
        .i_wr_offset  (s_axis_tdata[72:42]),
        .i_search_key (s_axis_tdata[104:73]),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_kind   (m_axis_tuser),
        .o_out_offset (w_out_offset),
        .o_out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, w_out_offset};

endmodule

// File: design/ckis_chk.sv
// Port-level checker for the chunked index key search block, with its bind.
module ckis_chk
    import ckis_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               s_axis_tvalid,
    input logic               s_axis_tready,
    input logic [0:0]         s_axis_tuser,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [31:0]        m_axis_tdata,
    input logic [KIND_W-1:0]  m_axis_tuser,
    input logic               m_axis_tlast
);

    // A stalled output beat holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("output beat changed while stalled");

    // Only closing beats carry tlast, and every closing beat does
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser != KIND_MATCH)))
        else $error("tlast and kind disagree");

    // Closing beats carry a zero position
    a_close_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata == '0)
        else $error("closing beat with nonzero position");

    // A query blocks the input until it finishes
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == CMD_QUERY) |=>
            !s_axis_tready)
        else $error("input taken during a query");

endmodule

bind chunked_index_key_search ckis_chk u_ckis_chk (.*);

// File: tb/chunked_index_key_search_check.sv
// Checker for the chunked index key search: tracks the table, predicts and compares output beats.
module chunked_index_key_search_check
    import ckis_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int CHUNK       = 64,
    parameter int MAX_MATCHES = 63
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [CNT_W-1:0]   i_cfg_data,
    input  logic               i_s_tvalid,
    input  logic               i_s_tready,
    input  logic [111:0]       i_s_tdata,   // entry_slot, entry_key, entry_offset, search_key
    input  logic [0:0]         i_s_tuser,   // cmd
    input  logic               i_m_tvalid,
    input  logic               i_m_tready,
    input  logic [31:0]        i_m_tdata,   // match_offset
    input  logic [KIND_W-1:0]  i_m_tuser,   // kind
    input  logic               i_m_tlast,
    output int                 o_pending,
    output int                 o_errors
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [OFFS_W-1:0] offs;
        logic              last;
    } t_match_beat;

    // Shadow copy of the index table and the entry count
    logic signed [KEY_W-1:0] key_tab [TABLE_DEPTH];
    logic [OFFS_W-1:0]       offs_tab [TABLE_DEPTH];
    logic [CNT_W-1:0]        entry_count;

    t_match_beat expected_beats [$];

    initial begin
        o_pending = 0;
        o_errors  = 0;
        entry_count = '0;
    end

    task automatic push_beat(input logic [KIND_W-1:0] kind, input logic [OFFS_W-1:0] offs,
                             input logic last);
        t_match_beat b;
        b.kind = kind;
        b.offs = offs;
        b.last = last;
        expected_beats.push_back(b);
    endtask

    // Lower bound per chunk, equal run from there, then the linear tail scan
    task automatic predict_query(input logic signed [KEY_W-1:0] want);
        int span, n_chunks, lo, hi, stop, mid, i, found;
        bit cut;
        span = (int'(entry_count) > TABLE_DEPTH) ? TABLE_DEPTH : int'(entry_count);
        n_chunks = span / CHUNK;
        found = 0;
        cut = 1'b0;
        for (int c = 0; c < n_chunks && !cut; c++) begin
            lo = c * CHUNK;
            hi = lo + CHUNK;
            stop = hi;
            while (lo < hi) begin
                mid = lo + ((hi - lo) >> 1);
                if (key_tab[mid] < want) lo = mid + 1;
                else hi = mid;
            end
            i = lo;
            while (i < stop && !cut && key_tab[i] == want) begin
                if (found >= MAX_MATCHES) begin
                    cut = 1'b1;
                end else begin
                    push_beat(KIND_MATCH, offs_tab[i], 1'b0);
                    found++;
                end
                i++;
            end
        end
        for (i = n_chunks * CHUNK; i < span && !cut; i++) begin
            if (key_tab[i] == want) begin
                if (found >= MAX_MATCHES) begin
                    cut = 1'b1;
                end else begin
                    push_beat(KIND_MATCH, offs_tab[i], 1'b0);
                    found++;
                end
            end
        end
        push_beat(cut ? KIND_TRUNC : KIND_DONE, '0, 1'b1);
    endtask

    // Watch all three channels at the rising edge
    always @(posedge i_clk) begin
        t_match_beat want_beat;
        if (!i_rst_n) begin
            entry_count = '0;
            expected_beats.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) entry_count = i_cfg_data;

            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser[0] == CMD_WRITE) begin
                    if (int'(i_s_tdata[9:0]) < TABLE_DEPTH) begin
                        key_tab[i_s_tdata[9:0]]  = i_s_tdata[41:10];
                        offs_tab[i_s_tdata[9:0]] = i_s_tdata[72:42];
                    end
                end else begin
                    predict_query(i_s_tdata[104:73]);
                end
            end

            if (i_m_tvalid && i_m_tready) begin
                if (expected_beats.size() == 0) begin
                    $display("%0t: unexpected output beat kind %0d data %h last %0b",
                             $time, i_m_tuser, i_m_tdata, i_m_tlast);
                    o_errors++;
                end else begin
                    want_beat = expected_beats.pop_front();
                    if (i_m_tuser !== want_beat.kind || i_m_tdata !== {1'b0, want_beat.offs}
                        || i_m_tlast !== want_beat.last) begin
                        $display("%0t: beat mismatch: expected kind %0d data %h last %0b,",
                                 $time, want_beat.kind, {1'b0, want_beat.offs},
                                 want_beat.last,
                                 " got kind %0d data %h last %0b",
                                 i_m_tuser, i_m_tdata, i_m_tlast);
                        o_errors++;
                    end
                end
            end
        end
        o_pending = expected_beats.size();
    end

endmodule

// File: tb/chunked_index_key_search_test.sv
// Top of the chunked index key search testbench: clock, reset, stimulus and verdict.
module chunked_index_key_search_test
    import ckis_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH = 1024;
    localparam int CHUNK       = 64;
    localparam int MAX_MATCHES = 63;
    localparam int RAND_ITEMS  = 230;
    localparam int SETTLE      = 6;
    localparam int END_SETTLE  = 20;
    localparam int QUIET_LIMIT = 4000;
    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CNT_W-1:0]   cfg_data = '0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [111:0]       s_tdata = '0;
    logic [0:0]         s_tuser = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [31:0]        m_tdata;
    logic [KIND_W-1:0]  m_tuser;
    logic               m_tlast;
    int                 pending;
    int                 errors;

    // Stimulus-side view of the table: keys written and the written prefix
    logic signed [KEY_W-1:0] shadow_key [TABLE_DEPTH];
    int  filled = 0;
    int  fill_style = 0;
    bit  calm = 1'b0;
    int  quiet_cycles = 0;

    always #2 clk = ~clk;

    chunked_index_key_search #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .CHUNK(CHUNK),
        .MAX_MATCHES(MAX_MATCHES)
    ) uut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_data(cfg_data),
        .s_axis_tvalid(s_tvalid),
        .s_axis_tready(s_tready),
        .s_axis_tdata(s_tdata),
        .s_axis_tuser(s_tuser),
        .m_axis_tvalid(m_tvalid),
        .m_axis_tready(m_tready),
        .m_axis_tdata(m_tdata),
        .m_axis_tuser(m_tuser),
        .m_axis_tlast(m_tlast)
    );

    chunked_index_key_search_check #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .CHUNK(CHUNK),
        .MAX_MATCHES(MAX_MATCHES)
    ) u_check (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_cfg_valid(cfg_valid),
        .i_cfg_ready(cfg_ready),
        .i_cfg_data(cfg_data),
        .i_s_tvalid(s_tvalid),
        .i_s_tready(s_tready),
        .i_s_tdata(s_tdata),
        .i_s_tuser(s_tuser),
        .i_m_tvalid(m_tvalid),
        .i_m_tready(m_tready),
        .i_m_tdata(m_tdata),
        .i_m_tuser(m_tuser),
        .i_m_tlast(m_tlast),
        .o_pending(pending),
        .o_errors(errors)
    );

    // Mostly short gaps, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    function automatic logic [111:0] pack_item(input logic [SLOT_W-1:0] slot,
                                               input logic [KEY_W-1:0] key,
                                               input logic [OFFS_W-1:0] offs,
                                               input logic [KEY_W-1:0] skey);
        return {7'b0, skey, offs, key, slot};
    endfunction

    // Receiver: bursts of ready with random stalls in between
    initial begin
        forever begin
            int hold, g;
            hold = $urandom_range(1, 24);
            g = calm ? 0 : gap_len();
            @(negedge clk);
            m_tready <= 1'b1;
            repeat (hold - 1) @(negedge clk);
            if (g > 0) begin
                @(negedge clk);
                m_tready <= 1'b0;
                repeat (g - 1) @(negedge clk);
            end
        end
    end

    // Watchdog on cycles without any accepted beat
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no beat accepted for %0d cycles", $time, QUIET_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // One input beat; valid stays high until the next call or an idle wait lowers it
    task automatic send_beat(input logic cmd, input logic [111:0] data);
        int g;
        g = calm ? 0 : gap_len();
        @(negedge clk);
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= cmd;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic write_entry(input int slot, input logic signed [KEY_W-1:0] key,
                               input logic [OFFS_W-1:0] offs);
        shadow_key[slot] = key;
        send_beat(CMD_WRITE, pack_item(slot[SLOT_W-1:0], key, offs, $urandom()));
    endtask

    task automatic run_query(input logic signed [KEY_W-1:0] key);
        send_beat(CMD_QUERY, pack_item(SLOT_W'($urandom_range(0, TABLE_DEPTH - 1)),
                                       $urandom(), OFFS_W'($urandom()), key));
    endtask

    // Drain all expected beats, then let a trailing write settle
    task automatic wait_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic set_entry_count(input int n);
        wait_idle();
        cfg_data  <= n[CNT_W-1:0];
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Extend the written prefix with sorted chunks of several shapes
    task automatic fill_to(input int n);
        int k, pos;
        if (n > TABLE_DEPTH) n = TABLE_DEPTH;
        while (filled < n) begin
            pos = filled % CHUNK;
            if (pos == 0) begin
                fill_style = $urandom_range(0, 3);
                if (fill_style == 3) k = 0;
                else if (fill_style == 1) k = KEY_MIN;
                else k = -6 + int'($urandom_range(0, 3));
            end else if (fill_style == 1 && pos == 1) begin
                k = -6 + int'($urandom_range(0, 3));
            end else if (fill_style == 1 && pos == CHUNK - 1) begin
                k = KEY_MAX;
            end else begin
                k = shadow_key[filled - 1];
                if (fill_style == 2) begin
                    if ($urandom_range(0, 15) == 0) k = k + 1;
                end else if (fill_style != 3) begin
                    if ($urandom_range(0, 3) == 0) k = k + 1;
                end
            end
            write_entry(filled, k, OFFS_W'($urandom()));
            filled++;
        end
    endtask

    function automatic logic signed [KEY_W-1:0] pick_search_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4) return KEY_MIN;
        if (r < 8) return KEY_MAX;
        if (r < 20) return $urandom();
        if (r < 35) return 0;
        return int'($urandom_range(0, 24)) - 8;
    endfunction

    // Mostly queries and order-keeping rewrites, some order-breaking noise
    task automatic random_item();
        int r, s;
        r = $urandom_range(0, 99);
        if (r < 60 || filled == 0) begin
            run_query(pick_search_key());
        end else begin
            s = $urandom_range(0, filled - 1);
            if (r < 72) begin
                write_entry(s, shadow_key[s], OFFS_W'($urandom()));
            end else if (r < 82 && s % CHUNK != 0) begin
                write_entry(s, shadow_key[s - 1], OFFS_W'($urandom()));
            end else if (r < 92) begin
                write_entry(s, int'($urandom_range(0, 24)) - 8, OFFS_W'($urandom()));
            end else begin
                write_entry($urandom_range(0, TABLE_DEPTH - 1), $urandom(),
                            OFFS_W'($urandom()));
            end
        end
    endtask

    task automatic run_phase(input int cnt, input int n_items);
        fill_to(cnt);
        set_entry_count(cnt);
        calm = ($urandom_range(0, 3) == 0);
        repeat (n_items) random_item();
    endtask

    initial begin
        int done_items, cnt, r, n;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty table, extreme keys and offsets, tail-only searches
        run_query(0);
        write_entry(0, KEY_MIN, '0);
        write_entry(1, KEY_MAX, 31'h7FFF_FFFF);
        write_entry(2, 5, OFFS_W'($urandom()));
        write_entry(3, -1, OFFS_W'($urandom()));
        write_entry(4, 5, OFFS_W'($urandom()));
        write_entry(5, 0, '0);
        filled = 6;
        set_entry_count(6);
        run_query(KEY_MIN);
        run_query(KEY_MAX);
        run_query(5);
        run_query(-1);
        run_query(0);
        run_query(3);
        set_entry_count(5);
        run_query(5);
        run_query(0);
        set_entry_count(0);
        run_query(KEY_MIN);

        // Random phases with mostly small counts
        done_items = 0;
        while (done_items < RAND_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 20) cnt = CHUNK * $urandom_range(1, 3);
            else if (r < 35) cnt = $urandom_range(0, CHUNK - 1);
            else cnt = $urandom_range(CHUNK, 3 * CHUNK + 40);
            n = $urandom_range(15, 40);
            run_phase(cnt, n);
            done_items += n;
        end

        wait_idle();
        repeat (END_SETTLE) @(negedge clk);
        if (errors == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
